FILE: rtl/i2c_master_byte_engine_defines.svh
// Assertion macros shared by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define I2CM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("i2cm assertion failed");
// Check a property on every clock edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT(lbl, prop)
`define I2CM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master byte engine.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  localparam int unsigned HalfW           = 16;
  localparam logic [HalfW-1:0] HalfReset  = 16'd100;
  localparam int unsigned DividerWidthDef = 16;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QPtrW           = 2;
  localparam int unsigned InTdataW        = 16;
  localparam int unsigned InTuserW        = 3;
  localparam int unsigned OutTdataW       = 16;
  localparam logic [3:0]  SlotCount       = 4'd8;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_ST1  = 9'b000000010,
    PH_ST2  = 9'b000000100,
    PH_ST3  = 9'b000001000,
    PH_SP1  = 9'b000010000,
    PH_SP2  = 9'b000100000,
    PH_SP3  = 9'b001000000,
    PH_BLO  = 9'b010000000,
    PH_BHI  = 9'b100000000
  } phase_e;

  // One classified tick as it waits in the queue.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] wr_byte;
    logic       send_ack;
    logic       sda;
    logic       scl;
  } tick_t;

  // Result word, sda_pull_low in the lowest bit.
  typedef struct packed {
    logic       ack_bit;
    logic [7:0] rd_byte;
    logic       done_res;
    logic       busy_res;
    logic       scl_pull_low;
    logic       sda_pull_low;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: rtl/i2cm_front.sv
// Input side: accepts ticks and classifies the request code.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InTdataW-1:0] s_axis_tdata,
  input  wire logic [InTuserW-1:0] s_axis_tuser,
  input  wire q_status_t           q_status_i,
  output logic                     push_o,
  output tick_t                    entry_o
);

  cmd_e cmd;

  // Drop unused request codes to a plain tick.
  always_comb begin
    case (s_axis_tuser)
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: cmd = cmd_e'(s_axis_tuser);
      default:                                  cmd = CMD_NONE;
    endcase
  end

  assign s_axis_tready     = !q_status_i.full;
  assign push_o            = s_axis_tvalid && !q_status_i.full;
  assign entry_o.cmd       = cmd;
  assign entry_o.wr_byte   = s_axis_tdata[7:0];
  assign entry_o.send_ack  = s_axis_tdata[8];
  assign entry_o.sda       = s_axis_tdata[9];
  assign entry_o.scl       = s_axis_tdata[10];

endmodule
`default_nettype wire

FILE: rtl/i2cm_queue.sv
// Short tick queue between the front and the bus sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_engine_defines.svh"
module i2cm_queue
  import i2cm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire tick_t entry_i,
  input  wire logic  pop_i,
  output tick_t      head_o,
  output q_status_t  status_o
);

  tick_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == (QPtrW+1)'(QueueDepth));
  assign status_o.empty = (count_q == '0);

  `I2CM_ASSERT_ALWAYS(a_count_bound, count_q <= (QPtrW+1)'(QueueDepth))
  `I2CM_ASSERT(a_no_pop_empty, status_o.empty |-> !pop_i)
  `I2CM_ASSERT(a_ptr_gap, QPtrW'(wr_ptr_q - rd_ptr_q) == count_q[QPtrW-1:0])

endmodule
`default_nettype wire

FILE: rtl/i2cm_back.sv
// Bus sequencer: runs start, stop and byte phases one tick at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_engine_defines.svh"
module i2cm_back
  import i2cm_pkg::*;
#(
  parameter int unsigned DIVIDER_WIDTH = DividerWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [HalfW-1:0]     cfg_data_i,
  input  wire tick_t                head_i,
  input  wire q_status_t            q_status_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata
);

  localparam int unsigned CmpW = (DIVIDER_WIDTH + 1 > HalfW) ? DIVIDER_WIDTH + 1 : HalfW;

  logic [HalfW-1:0]         half_q;
  phase_e                   phase_q, phase_d;
  cmd_e                     cmd_q, cmd_d;
  logic [3:0]               bit_q, bit_d;
  logic [7:0]               shift_q, shift_d, shift_nx;
  logic [DIVIDER_WIDTH-1:0] tick_q, tick_d, tick_adv, tick_str;
  logic [DIVIDER_WIDTH:0]   tick_inc;
  logic                     ack_hold_q, ack_hold_d;
  logic [7:0]               rd_hold_q, rd_hold_d;
  logic                     ack_send_q, ack_send_d;
  logic                     sda_q, sda_d, scl_q, scl_d;
  logic                     elapsed, str_elapsed, finish;
  logic                     out_valid_q;
  res_t                     out_q;

  assign pop_o = !q_status_i.empty && (!out_valid_q || m_axis_tready);

  always_comb begin
    tick_inc    = {1'b0, tick_q} + 1'b1;
    // Reaching 2^DIVIDER_WIDTH always ends the half period.
    elapsed     = tick_inc[DIVIDER_WIDTH] || (CmpW'(tick_inc) >= CmpW'(half_q));
    tick_adv    = elapsed ? '0 : tick_inc[DIVIDER_WIDTH-1:0];
    str_elapsed = head_i.scl && elapsed;
    tick_str    = head_i.scl ? tick_adv : '0;
    shift_nx    = {shift_q[6:0], (cmd_q == CMD_READ) ? head_i.sda : 1'b0};

    phase_d    = phase_q;
    cmd_d      = cmd_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    tick_d     = tick_q;
    ack_hold_d = ack_hold_q;
    rd_hold_d  = rd_hold_q;
    ack_send_d = ack_send_q;
    sda_d      = sda_q;
    scl_d      = scl_q;
    finish     = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        tick_d = '0;
        case (head_i.cmd)
          CMD_START: begin
            cmd_d = CMD_START; phase_d = PH_ST1; sda_d = 1'b0; scl_d = 1'b0;
          end
          CMD_STOP: begin
            cmd_d = CMD_STOP; phase_d = PH_SP1; sda_d = 1'b1; scl_d = 1'b1;
          end
          CMD_WRITE: begin
            cmd_d = CMD_WRITE; phase_d = PH_BLO; bit_d = '0;
            shift_d = head_i.wr_byte; ack_send_d = head_i.send_ack;
            scl_d = 1'b1; sda_d = !head_i.wr_byte[7];
          end
          CMD_READ: begin
            cmd_d = CMD_READ; phase_d = PH_BLO; bit_d = '0;
            shift_d = '0; ack_send_d = head_i.send_ack;
            scl_d = 1'b1; sda_d = 1'b0;
          end
          default: ;
        endcase
      end
      PH_ST1: begin
        tick_d = tick_str;
        if (str_elapsed) begin
          phase_d = PH_ST2; sda_d = 1'b1;
        end
      end
      PH_ST2: begin
        tick_d = tick_adv;
        if (elapsed) begin
          phase_d = PH_ST3; scl_d = 1'b1;
        end
      end
      PH_ST3: begin
        tick_d = tick_adv;
        finish = elapsed;
      end
      PH_SP1: begin
        tick_d = tick_adv;
        if (elapsed) begin
          phase_d = PH_SP2; scl_d = 1'b0;
        end
      end
      PH_SP2: begin
        tick_d = tick_str;
        if (str_elapsed) begin
          phase_d = PH_SP3; sda_d = 1'b0;
        end
      end
      PH_SP3: begin
        tick_d = tick_adv;
        finish = elapsed;
      end
      PH_BLO: begin
        tick_d = tick_adv;
        if (elapsed) begin
          phase_d = PH_BHI; scl_d = 1'b0;
        end
      end
      PH_BHI: begin
        tick_d = tick_str;
        if (str_elapsed) begin
          scl_d = 1'b1;
          if (bit_q < SlotCount) begin
            shift_d = shift_nx;
            bit_d   = bit_q + 1'b1;
            phase_d = PH_BLO;
            // Next slot: data bit while below eight, then the ack slot.
            if (bit_q + 1'b1 < SlotCount) begin
              sda_d = (cmd_q == CMD_WRITE) && !shift_nx[7];
            end else begin
              sda_d = (cmd_q == CMD_READ) && ack_send_q;
            end
          end else begin
            if (cmd_q == CMD_READ) begin
              rd_hold_d = shift_q;
            end else begin
              ack_hold_d = head_i.sda;
            end
            finish = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        cmd_d   = CMD_NONE;
        tick_d  = '0;
      end
    endcase

    if (finish) begin
      phase_d = PH_IDLE;
      cmd_d   = CMD_NONE;
      tick_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= HalfReset;
      phase_q     <= PH_IDLE;
      cmd_q       <= CMD_NONE;
      bit_q       <= '0;
      shift_q     <= '0;
      tick_q      <= '0;
      ack_hold_q  <= 1'b1;
      rd_hold_q   <= '0;
      ack_send_q  <= 1'b0;
      sda_q       <= 1'b0;
      scl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        // Hold a zero half period as one tick.
        half_q <= (cfg_data_i == '0) ? HalfW'(1) : cfg_data_i;
      end
      if (pop_o) begin
        phase_q    <= phase_d;
        cmd_q      <= cmd_d;
        bit_q      <= bit_d;
        shift_q    <= shift_d;
        tick_q     <= tick_d;
        ack_hold_q <= ack_hold_d;
        rd_hold_q  <= rd_hold_d;
        ack_send_q <= ack_send_d;
        sda_q      <= sda_d;
        scl_q      <= scl_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.sda_pull_low <= sda_d;
      out_q.scl_pull_low <= scl_d;
      out_q.busy_res     <= (phase_d != PH_IDLE);
      out_q.done_res     <= finish;
      out_q.rd_byte      <= rd_hold_d;
      out_q.ack_bit      <= ack_hold_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(out_q);

  `I2CM_ASSERT(a_idle_no_cmd, (phase_q == PH_IDLE) |-> (cmd_q == CMD_NONE))
  `I2CM_ASSERT_ALWAYS(a_bit_bound, bit_q <= SlotCount)
  `I2CM_ASSERT(a_pop_loads_out, pop_o |=> out_valid_q)
  `I2CM_ASSERT(a_done_not_busy, out_valid_q |-> !(out_q.done_res && out_q.busy_res))

endmodule
`default_nettype wire

FILE: rtl/i2c_master_byte_engine.sv
// I2C master byte engine top level: tick front end, queue and bus sequencer.
// Path: an accepted tick is written into the queue, then its result is registered at pop.
// Throughput: one tick per cycle while the queue is not full; the sequencer retires
// one queued tick per cycle whenever its output register is free or being drained.
// Stalls: input ready drops only while the four-entry tick queue is full.
// Reset (async, active low): idle, both lines released, half period 100, ack bit 1.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned DIVIDER_WIDTH = DividerWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [HalfW-1:0]     cfg_data_i,     // half_period_ticks
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // wr_byte, send_ack, sda_in, scl_in
  input  wire logic [InTuserW-1:0]  s_axis_tuser,   // req_type
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata    // sda_pull_low, scl_pull_low,
                                                    // busy_res, done_res, rd_byte, ack_bit
);

  q_status_t q_status;
  tick_t     entry, head;
  logic      push, pop;

  assign cfg_ready_o = 1'b1;

  i2cm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (entry)
  );

  i2cm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  i2cm_back #(
    .DIVIDER_WIDTH (DIVIDER_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
